// File: hw/rtl/b3sh_pkg.sv
// ----------------------------------------------------------------------------
// b3sh_pkg
// Shared types and constants of the BLAKE3 stream hasher.
// ----------------------------------------------------------------------------
package b3sh_pkg;

    localparam logic [3:0] FLAG_CHUNK_START = 4'd1;
    localparam logic [3:0] FLAG_CHUNK_END   = 4'd2;
    localparam logic [3:0] FLAG_PARENT      = 4'd4;
    localparam logic [3:0] FLAG_ROOT        = 4'd8;

    localparam int BLOCK_BYTES  = 64;
    localparam int CHUNK_BLOCKS = 16;
    localparam int ROUNDS       = 7;

    typedef logic [31:0] word_t;

    // hash sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_INIT,
        ST_CMP_G,
        ST_CMP_FIN,
        ST_AFTER,
        ST_STK_RD,
        ST_STK_WAIT,
        ST_PUSH,
        ST_OUT
    } state_t;

    // what a running compression is for
    typedef enum logic [2:0] {
        JOB_BLOCK,
        JOB_CLOSE,
        JOB_MERGE,
        JOB_FINAL,
        JOB_ROOT
    } job_t;

    function automatic word_t iv_word(input logic [2:0] i);
        case (i)
            3'd0:    iv_word = 32'h6A09E667;
            3'd1:    iv_word = 32'hBB67AE85;
            3'd2:    iv_word = 32'h3C6EF372;
            3'd3:    iv_word = 32'hA54FF53A;
            3'd4:    iv_word = 32'h510E527F;
            3'd5:    iv_word = 32'h9B05688C;
            3'd6:    iv_word = 32'h1F83D9AB;
            default: iv_word = 32'h5BE0CD19;
        endcase
    endfunction

    function automatic logic [3:0] msg_perm(input logic [3:0] i);
        case (i)
            4'd0:    msg_perm = 4'd2;
            4'd1:    msg_perm = 4'd6;
            4'd2:    msg_perm = 4'd3;
            4'd3:    msg_perm = 4'd10;
            4'd4:    msg_perm = 4'd7;
            4'd5:    msg_perm = 4'd0;
            4'd6:    msg_perm = 4'd4;
            4'd7:    msg_perm = 4'd13;
            4'd8:    msg_perm = 4'd1;
            4'd9:    msg_perm = 4'd11;
            4'd10:   msg_perm = 4'd12;
            4'd11:   msg_perm = 4'd5;
            4'd12:   msg_perm = 4'd9;
            4'd13:   msg_perm = 4'd14;
            4'd14:   msg_perm = 4'd15;
            default: msg_perm = 4'd8;
        endcase
    endfunction

endpackage

// File: hw/rtl/blake3_stream_hasher.sv
// ----------------------------------------------------------------------------
// blake3_stream_hasher
// Unkeyed BLAKE3 over a byte stream, one shared G unit under a sequencer.
// ----------------------------------------------------------------------------
// Sequence: a byte request is accepted, then written into the block buffer; one that
//   opens a new block first runs a compression (an init step, 7 x 8 G steps, a finish step).
// Chunk close: one compression, then per merge a stack read, a read wait and a
//   compression, and a push. A last item costs (height + 1) compressions, a stack
//   read and wait per parent, then 8 output words. Requests are taken one at a time.
// Reset clears all control state; the stack memory is never cleared.
module blake3_stream_hasher #(
    parameter int STACK_DEPTH = 54
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    b3sh_pkg::state_t state_reg, state_next;
    b3sh_pkg::job_t   job_reg;

    b3sh_pkg::word_t cv_reg [8];
    b3sh_pkg::word_t msg_reg [16];
    b3sh_pkg::word_t v_reg [16];
    b3sh_pkg::word_t ccv_reg [8];
    b3sh_pkg::word_t out_reg [16];
    logic [6:0]  fill_reg;
    logic [3:0]  blocks_reg;
    logic [63:0] chunk_reg;
    logic [63:0] total_reg;
    logic [HW-1:0] height_reg;
    logic [HW-1:0] h_reg;
    logic [2:0]  g_reg;
    logic [2:0]  round_reg;
    logic [2:0]  widx_reg;
    logic        pend_byte_reg;
    logic        pend_last_reg;
    logic [7:0]  pend_data_reg;
    logic [63:0] cmp_ctr_reg;
    logic [6:0]  cmp_len_reg;
    logic [3:0]  cmp_fl_reg;
    logic        merge_go;

    // stack memory, one 256-bit chaining value per entry
    logic [255:0] stack_mem [STACK_DEPTH];
    logic [255:0] stk_rd_reg;
    logic [AW-1:0] stk_addr;
    logic          stk_we;

    // shared G unit
    logic [3:0] ia, ib, ic, id;
    b3sh_pkg::word_t ga, gb, gc, gd, gx, gy;
    b3sh_pkg::word_t na, nb, nc, nd, t0, t1, t2, t3;

    always_comb begin
        case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        ga = v_reg[ia];
        gb = v_reg[ib];
        gc = v_reg[ic];
        gd = v_reg[id];
        gx = msg_reg[{g_reg, 1'b0}];
        gy = msg_reg[{g_reg, 1'b1}];
        t0 = ga + gb + gx;
        t1 = gd ^ t0;
        t1 = {t1[15:0], t1[31:16]};
        t2 = gc + t1;
        t3 = gb ^ t2;
        t3 = {t3[11:0], t3[31:12]};
        na = t0 + t3 + gy;
        nd = t1 ^ na;
        nd = {nd[7:0], nd[31:8]};
        nc = t2 + nd;
        nb = t3 ^ nc;
        nb = {nb[6:0], nb[31:7]};
    end

    wire s_fire = s_tvalid && s_tready;
    wire m_fire = m_tvalid && m_tready;
    wire last_g = (g_reg == 3'd7) && (round_reg == 3'(b3sh_pkg::ROUNDS - 1));

    // another merge while the shifted chunk count is even and the stack holds entries
    assign merge_go = (((job_reg == b3sh_pkg::JOB_MERGE) ? total_reg[1]
                                                         : total_reg[0]) == 1'b0)
                      && (height_reg != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            b3sh_pkg::ST_IDLE:     if (s_fire) state_next = b3sh_pkg::ST_AFTER;
            b3sh_pkg::ST_AFTER: begin
                if (pend_byte_reg && fill_reg == 7'(b3sh_pkg::BLOCK_BYTES))
                    state_next = b3sh_pkg::ST_CMP_INIT;
                else if (pend_byte_reg)
                    state_next = pend_last_reg ? b3sh_pkg::ST_AFTER : b3sh_pkg::ST_IDLE;
                else if (pend_last_reg)
                    state_next = b3sh_pkg::ST_CMP_INIT;
                else
                    state_next = b3sh_pkg::ST_IDLE;
            end
            b3sh_pkg::ST_CMP_INIT: state_next = b3sh_pkg::ST_CMP_G;
            b3sh_pkg::ST_CMP_G:    if (last_g) state_next = b3sh_pkg::ST_CMP_FIN;
            b3sh_pkg::ST_CMP_FIN: begin
                case (job_reg)
                    b3sh_pkg::JOB_BLOCK: state_next = b3sh_pkg::ST_AFTER;
                    b3sh_pkg::JOB_CLOSE, b3sh_pkg::JOB_MERGE:
                        state_next = merge_go ? b3sh_pkg::ST_STK_RD : b3sh_pkg::ST_PUSH;
                    b3sh_pkg::JOB_FINAL: state_next = b3sh_pkg::ST_STK_RD;
                    default:             state_next = b3sh_pkg::ST_OUT;
                endcase
            end
            b3sh_pkg::ST_STK_RD:   state_next = b3sh_pkg::ST_STK_WAIT;
            b3sh_pkg::ST_STK_WAIT: state_next = b3sh_pkg::ST_CMP_INIT;
            b3sh_pkg::ST_PUSH:     state_next = b3sh_pkg::ST_AFTER;
            b3sh_pkg::ST_OUT:      if (m_fire && widx_reg == 3'd7)
                                       state_next = b3sh_pkg::ST_IDLE;
            default:               state_next = b3sh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == b3sh_pkg::ST_IDLE);
        m_tvalid = (state_reg == b3sh_pkg::ST_OUT);
        m_tdata  = {out_reg[{widx_reg, 1'b1}], out_reg[{widx_reg, 1'b0}]};
        m_tuser  = widx_reg;
        m_tlast  = (widx_reg == 3'd7);
    end

    assign stk_we   = (state_reg == b3sh_pkg::ST_PUSH) && (height_reg < HW'(STACK_DEPTH));
    assign stk_addr = (state_reg == b3sh_pkg::ST_PUSH) ? height_reg[AW-1:0]
                                                       : h_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_addr] <= {ccv_reg[7], ccv_reg[6], ccv_reg[5], ccv_reg[4],
                                    ccv_reg[3], ccv_reg[2], ccv_reg[1], ccv_reg[0]};
        end
        stk_rd_reg <= stack_mem[stk_addr];
    end

    // main sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= b3sh_pkg::ST_IDLE;
            job_reg       <= b3sh_pkg::JOB_BLOCK;
            fill_reg      <= '0;
            blocks_reg    <= '0;
            chunk_reg     <= '0;
            height_reg    <= '0;
            h_reg         <= '0;
            g_reg         <= '0;
            round_reg     <= '0;
            widx_reg      <= '0;
            pend_byte_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            total_reg     <= '0;
            for (int i = 0; i < 8; i++) cv_reg[i] <= b3sh_pkg::iv_word(3'(i));
            for (int i = 0; i < 16; i++) msg_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                b3sh_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        pend_byte_reg <= s_tuser;
                        pend_last_reg <= s_tlast;
                        pend_data_reg <= s_tdata;
                    end
                end
                b3sh_pkg::ST_AFTER: begin
                    if (pend_byte_reg && fill_reg == 7'(b3sh_pkg::BLOCK_BYTES)) begin
                        // full block waits on a new byte
                        cmp_ctr_reg <= chunk_reg;
                        cmp_len_reg <= 7'(b3sh_pkg::BLOCK_BYTES);
                        if (blocks_reg == 4'(b3sh_pkg::CHUNK_BLOCKS - 1)) begin
                            job_reg    <= b3sh_pkg::JOB_CLOSE;
                            cmp_fl_reg <= b3sh_pkg::FLAG_CHUNK_END;
                            total_reg  <= chunk_reg + 64'd1;
                        end else begin
                            job_reg    <= b3sh_pkg::JOB_BLOCK;
                            cmp_fl_reg <= (blocks_reg == 4'd0) ?
                                          b3sh_pkg::FLAG_CHUNK_START : 4'd0;
                        end
                    end else if (pend_byte_reg) begin
                        msg_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= pend_data_reg;
                        fill_reg      <= fill_reg + 7'd1;
                        pend_byte_reg <= 1'b0;
                    end else if (pend_last_reg) begin
                        pend_last_reg <= 1'b0;
                        cmp_len_reg   <= fill_reg;
                        cmp_fl_reg    <= b3sh_pkg::FLAG_CHUNK_END |
                                         ((blocks_reg == 4'd0) ?
                                          b3sh_pkg::FLAG_CHUNK_START : 4'd0) |
                                         ((height_reg == '0) ? b3sh_pkg::FLAG_ROOT : 4'd0);
                        cmp_ctr_reg   <= (height_reg == '0) ? 64'd0 : chunk_reg;
                        job_reg       <= (height_reg == '0) ? b3sh_pkg::JOB_ROOT
                                                            : b3sh_pkg::JOB_FINAL;
                        h_reg         <= height_reg;
                    end
                end
                b3sh_pkg::ST_CMP_INIT: begin
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i]   <= cv_reg[i];
                        v_reg[i+8] <= b3sh_pkg::iv_word(3'(i & 3));
                    end
                    v_reg[12] <= cmp_ctr_reg[31:0];
                    v_reg[13] <= cmp_ctr_reg[63:32];
                    v_reg[14] <= {25'd0, cmp_len_reg};
                    v_reg[15] <= {28'd0, cmp_fl_reg};
                    g_reg     <= '0;
                    round_reg <= '0;
                end
                b3sh_pkg::ST_CMP_G: begin
                    v_reg[ia] <= na;
                    v_reg[ib] <= nb;
                    v_reg[ic] <= nc;
                    v_reg[id] <= nd;
                    g_reg     <= g_reg + 3'd1;
                    if (g_reg == 3'd7) begin
                        round_reg <= round_reg + 3'd1;
                        for (int i = 0; i < 16; i++)
                            msg_reg[i] <= msg_reg[b3sh_pkg::msg_perm(4'(i))];
                    end
                end
                b3sh_pkg::ST_CMP_FIN: begin
                    for (int i = 0; i < 8; i++) begin
                        ccv_reg[i]   <= v_reg[i] ^ v_reg[i+8];
                        out_reg[i]   <= v_reg[i] ^ v_reg[i+8];
                        out_reg[i+8] <= v_reg[i+8] ^ cv_reg[i];
                    end
                    case (job_reg)
                        b3sh_pkg::JOB_BLOCK: begin
                            for (int i = 0; i < 8; i++) cv_reg[i] <= v_reg[i] ^ v_reg[i+8];
                            for (int i = 0; i < 16; i++) msg_reg[i] <= '0;
                            blocks_reg <= blocks_reg + 4'd1;
                            fill_reg   <= '0;
                        end
                        b3sh_pkg::JOB_CLOSE, b3sh_pkg::JOB_MERGE: begin
                            if (job_reg == b3sh_pkg::JOB_MERGE)
                                total_reg <= {1'b0, total_reg[63:1]};
                            if (merge_go) begin
                                height_reg <= height_reg - HW'(1);
                                h_reg      <= height_reg - HW'(1);
                            end
                        end
                        b3sh_pkg::JOB_FINAL: begin
                            h_reg <= h_reg - HW'(1);
                        end
                        default: begin
                            widx_reg <= '0;
                        end
                    endcase
                end
                b3sh_pkg::ST_STK_RD: begin
                    if (job_reg == b3sh_pkg::JOB_CLOSE)
                        job_reg <= b3sh_pkg::JOB_MERGE;
                end
                b3sh_pkg::ST_STK_WAIT: begin
                    for (int i = 0; i < 8; i++) begin
                        msg_reg[i]   <= stk_rd_reg[32*i +: 32];
                        msg_reg[i+8] <= ccv_reg[i];
                        cv_reg[i]    <= b3sh_pkg::iv_word(3'(i));
                    end
                    cmp_len_reg <= 7'(b3sh_pkg::BLOCK_BYTES);
                    cmp_ctr_reg <= '0;
                    if (job_reg != b3sh_pkg::JOB_MERGE) begin
                        cmp_fl_reg <= b3sh_pkg::FLAG_PARENT |
                                      ((h_reg == '0) ? b3sh_pkg::FLAG_ROOT : 4'd0);
                        job_reg    <= (h_reg == '0) ? b3sh_pkg::JOB_ROOT
                                                    : b3sh_pkg::JOB_FINAL;
                    end else begin
                        cmp_fl_reg <= b3sh_pkg::FLAG_PARENT;
                    end
                end
                b3sh_pkg::ST_PUSH: begin
                    if (height_reg < HW'(STACK_DEPTH))
                        height_reg <= height_reg + HW'(1);
                    chunk_reg  <= chunk_reg + 64'd1;
                    for (int i = 0; i < 8; i++) cv_reg[i] <= b3sh_pkg::iv_word(3'(i));
                    for (int i = 0; i < 16; i++) msg_reg[i] <= '0;
                    fill_reg   <= '0;
                    blocks_reg <= '0;
                end
                b3sh_pkg::ST_OUT: begin
                    if (m_fire) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                cv_reg[i] <= b3sh_pkg::iv_word(3'(i));
                            for (int i = 0; i < 16; i++) msg_reg[i] <= '0;
                            fill_reg   <= '0;
                            blocks_reg <= '0;
                            chunk_reg  <= '0;
                            height_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: bench/tb_blake3_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_blake3_stream_hasher
// Streams random and directed messages into the BLAKE3 stream hasher, predicts
// each digest with a local BLAKE3 implementation and checks every output word.
// ----------------------------------------------------------------------------
module tb_blake3_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STK_DEPTH = 54;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    blake3_stream_hasher #(.STACK_DEPTH(STK_DEPTH)) dut (.*);

    always #5 aclk = ~aclk;

    byte_req_t   pending_reqs[$];
    digest_req_t expected_words[$];
    int          errors = 0;
    int          cycles = 0;
    int          messages = 0;
    int          words_seen = 0;
    bit          hold_off = 1'b0;

    // predictor state
    b3sh_pkg::word_t p_cv[8];
    logic [7:0]      p_buf[64];
    int              p_fill;
    int              p_blocks;
    logic [63:0]     p_chunk;
    b3sh_pkg::word_t p_stack[STK_DEPTH][8];
    int              p_height;

    function automatic b3sh_pkg::word_t rotr(b3sh_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void mix(inout b3sh_pkg::word_t v[16], input int a, int b, int c,
                                int d, input b3sh_pkg::word_t x, b3sh_pkg::word_t y);
        v[a] = v[a] + v[b] + x;
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + y;
        v[d] = rotr(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 7);
    endfunction

    function automatic void compress(input b3sh_pkg::word_t cv[8],
                                     input b3sh_pkg::word_t msg[16],
                                     input logic [63:0] ctr, input b3sh_pkg::word_t len,
                                     input logic [3:0] fl,
                                     output b3sh_pkg::word_t res[16]);
        b3sh_pkg::word_t v[16];
        b3sh_pkg::word_t m[16];
        b3sh_pkg::word_t t[16];
        logic [3:0] order[16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
        for (int i = 0; i < 8; i++) begin
            v[i] = cv[i];
            v[i + 8] = b3sh_pkg::iv_word(3'(i & 3));
        end
        v[12] = ctr[31:0];
        v[13] = ctr[63:32];
        v[14] = len;
        v[15] = {28'd0, fl};
        m = msg;
        for (int r = 0; r < 7; r++) begin
            mix(v, 0, 4, 8, 12, m[0], m[1]);
            mix(v, 1, 5, 9, 13, m[2], m[3]);
            mix(v, 2, 6, 10, 14, m[4], m[5]);
            mix(v, 3, 7, 11, 15, m[6], m[7]);
            mix(v, 0, 5, 10, 15, m[8], m[9]);
            mix(v, 1, 6, 11, 12, m[10], m[11]);
            mix(v, 2, 7, 8, 13, m[12], m[13]);
            mix(v, 3, 4, 9, 14, m[14], m[15]);
            for (int i = 0; i < 16; i++) t[i] = m[order[i]];
            m = t;
        end
        for (int i = 0; i < 8; i++) begin
            res[i] = v[i] ^ v[i + 8];
            res[i + 8] = v[i + 8] ^ cv[i];
        end
    endfunction

    function automatic void iv_cv(output b3sh_pkg::word_t cv[8]);
        for (int i = 0; i < 8; i++) cv[i] = b3sh_pkg::iv_word(3'(i));
    endfunction

    function automatic void buf_words(output b3sh_pkg::word_t w[16]);
        for (int i = 0; i < 16; i++)
            w[i] = {p_buf[4*i+3], p_buf[4*i+2], p_buf[4*i+1], p_buf[4*i]};
    endfunction

    function automatic logic [3:0] start_fl();
        return (p_blocks == 0) ? b3sh_pkg::FLAG_CHUNK_START : 4'd0;
    endfunction

    function automatic void new_chunk();
        iv_cv(p_cv);
        foreach (p_buf[i]) p_buf[i] = 8'd0;
        p_fill = 0;
        p_blocks = 0;
    endfunction

    function automatic void hasher_reset();
        new_chunk();
        p_chunk = '0;
        p_height = 0;
    endfunction

    // finish a chunk and merge it onto the subtree stack
    function automatic void finish_chunk();
        b3sh_pkg::word_t m[16];
        b3sh_pkg::word_t o[16];
        b3sh_pkg::word_t cv[8];
        b3sh_pkg::word_t ivs[8];
        logic [63:0] total;
        iv_cv(ivs);
        buf_words(m);
        compress(p_cv, m, p_chunk, b3sh_pkg::word_t'(p_fill),
                 start_fl() | b3sh_pkg::FLAG_CHUNK_END, o);
        for (int i = 0; i < 8; i++) cv[i] = o[i];
        total = p_chunk + 1;
        while (total[0] == 1'b0 && p_height > 0) begin
            p_height--;
            for (int i = 0; i < 8; i++) begin
                m[i] = p_stack[p_height][i];
                m[i + 8] = cv[i];
            end
            compress(ivs, m, '0, b3sh_pkg::word_t'(b3sh_pkg::BLOCK_BYTES),
                     b3sh_pkg::FLAG_PARENT, o);
            for (int i = 0; i < 8; i++) cv[i] = o[i];
            total = total >> 1;
        end
        if (p_height < STK_DEPTH) begin
            p_stack[p_height] = cv;
            p_height++;
        end
        p_chunk++;
        new_chunk();
    endfunction

    function automatic void take_byte(logic [7:0] b);
        b3sh_pkg::word_t m[16];
        b3sh_pkg::word_t o[16];
        if (p_fill >= b3sh_pkg::BLOCK_BYTES) begin
            if (p_blocks >= b3sh_pkg::CHUNK_BLOCKS - 1) begin
                finish_chunk();
            end else begin
                buf_words(m);
                compress(p_cv, m, p_chunk, b3sh_pkg::word_t'(b3sh_pkg::BLOCK_BYTES),
                         start_fl(), o);
                for (int i = 0; i < 8; i++) p_cv[i] = o[i];
                p_blocks++;
                foreach (p_buf[i]) p_buf[i] = 8'd0;
                p_fill = 0;
            end
        end
        p_buf[p_fill & 63] = b;
        p_fill++;
    endfunction

    // predict the digest words caused by one accepted request
    function automatic void predict_digest(byte_req_t r);
        b3sh_pkg::word_t icv[8];
        b3sh_pkg::word_t m[16];
        b3sh_pkg::word_t o[16];
        logic [63:0] ctr;
        b3sh_pkg::word_t len;
        logic [3:0] fl;
        int h;
        digest_req_t d;
        if (r.byte_valid) take_byte(r.data_byte);
        if (!r.last) return;
        icv = p_cv;
        buf_words(m);
        ctr = p_chunk;
        len = b3sh_pkg::word_t'(p_fill);
        fl = start_fl() | b3sh_pkg::FLAG_CHUNK_END;
        h = p_height;
        while (h > 0) begin
            h--;
            compress(icv, m, ctr, len, fl, o);
            for (int i = 0; i < 8; i++) begin
                m[i] = p_stack[h][i];
                m[i + 8] = o[i];
            end
            iv_cv(icv);
            ctr = '0;
            len = b3sh_pkg::word_t'(b3sh_pkg::BLOCK_BYTES);
            fl = b3sh_pkg::FLAG_PARENT;
        end
        compress(icv, m, '0, len, fl | b3sh_pkg::FLAG_ROOT, o);
        for (int k = 0; k < 8; k++) begin
            d.digest_word = {o[2*k+1], o[2*k]};
            d.word_index = 3'(k);
            d.last_word = (k == 7);
            expected_words.push_back(d);
        end
        messages++;
        hasher_reset();
    endfunction

    function automatic void add_msg(int len, bit end_with_byte);
        byte_req_t r;
        for (int i = 0; i < len; i++) begin
            r.data_byte = 8'($urandom);
            r.byte_valid = 1'b1;
            r.last = end_with_byte && (i == len - 1);
            pending_reqs.push_back(r);
            // occasional empty request that must be ignored
            if ($urandom_range(0, 15) == 0) begin
                r.byte_valid = 1'b0;
                r.last = 1'b0;
                pending_reqs.push_back(r);
            end
        end
        if (!end_with_byte || len == 0) begin
            r.data_byte = 8'($urandom);
            r.byte_valid = 1'b0;
            r.last = 1'b1;
            pending_reqs.push_back(r);
        end
    endfunction

    // sender: bursts and gaps, with a hold-off while results drain
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_digest({s_tdata, s_tuser, s_tlast});
            if (s_tvalid && !s_tready) begin
                // keep the current request
            end else if (gap_left > 0 || hold_off || pending_reqs.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                byte_req_t r;
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= r.data_byte;
                s_tuser <= r.byte_valid;
                s_tlast <= r.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stalls in its own rhythm, and monitor of the result channel
    int stall_phase = 0;
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $display("%0t: digest word expected none actual %h idx %0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    digest_req_t e;
                    e = expected_words.pop_front();
                    if (e.digest_word !== m_tdata)
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, e.digest_word, m_tdata);
                    if (e.word_index !== m_tuser)
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, e.word_index, m_tuser);
                    if (e.last_word !== m_tlast)
                        $display("%0t: last_word expected %0d actual %0d",
                                 $time, e.last_word, m_tlast);
                    if (e.digest_word !== m_tdata || e.word_index !== m_tuser ||
                        e.last_word !== m_tlast) errors++;
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            m_tready <= (stall_phase < 8) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        hasher_reset();
        // directed: empty message, single bytes, extremes, block edges
        add_msg(0, 0);
        add_msg(1, 1);
        add_msg(1, 0);
        begin
            byte_req_t r;
            r = '{8'hFF, 1'b1, 1'b0}; pending_reqs.push_back(r);
            r = '{8'h00, 1'b1, 1'b0}; pending_reqs.push_back(r);
            r = '{8'hAA, 1'b0, 1'b0}; pending_reqs.push_back(r);
            r = '{8'h55, 1'b1, 1'b1}; pending_reqs.push_back(r);
        end
        add_msg(64, 1);
        add_msg(65, 0);
        // random: mostly short messages with a few around block edges
        for (int n = 0; n < 6; n++) begin
            int len;
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(60, 68);
                default: len = $urandom_range(1, 20);
            endcase
            add_msg(len, $urandom_range(0, 1));
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // pause the sender once until the digests drain
        wait (messages >= 4);
        hold_off = 1'b1;
        wait (expected_words.size() == 0);
        hold_off = 1'b0;
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d messages (empty, short and block-edge sizes), %0d digest words",
                 messages, words_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
